### hw/rtl/assert_macros.svh
// Assertion macros shared by the run segmenter RTL.
// No dependencies; the macros expand to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### hw/rtl/rseg_pkg.sv
// Shared types and constants for the monotonic run segmenter.
// No dependencies.
`default_nettype none

package rseg_pkg;

  // Run direction codes
  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_RISE = 2'd1,
    DIR_FALL = 2'd2
  } rseg_dir_t;

  // Result kind codes
  localparam logic KIND_RUN = 1'b0;
  localparam logic KIND_EXT = 1'b1;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned LEN_W    = 12;
  localparam int unsigned CNT_W    = 11;
  localparam int unsigned CNT_MAX  = 2047;

  // Decoupling queue between front and back
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Result slot positions within one queue entry, in emit order
  localparam int unsigned SLOT_REV = 0;
  localparam int unsigned SLOT_FIN = 1;
  localparam int unsigned SLOT_EXT = 2;
  localparam int unsigned N_SLOTS  = 3;

  // Everything one input sample causes: up to three results
  typedef struct packed {
    logic                       rev_vld;
    logic signed [LEN_W-1:0]    rev_len;
    logic signed [SAMPLE_W-1:0] rev_val;
    logic                       fin_vld;
    logic signed [LEN_W-1:0]    fin_len;
    logic signed [SAMPLE_W-1:0] fin_val;
    logic                       ext_vld;
    logic signed [SAMPLE_W-1:0] ext_val;
  } rseg_entry_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } rseg_qstat_t;

endpackage

`default_nettype wire

### hw/rtl/rseg_front.sv
// Front end: accepts samples, tracks run state and classifies each sample
// into the results it causes. Depends on rseg_pkg.
`default_nettype none

module rseg_front
  import rseg_pkg::*;
#(
  parameter int unsigned MAX_RUN = 1024
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic signed [SAMPLE_W-1:0] in_sample,
  input  wire logic                       in_end_of_stream,
  input  wire rseg_qstat_t                q_stat,
  output logic                            q_push,
  output rseg_entry_t                     q_entry
);

  localparam int unsigned RunCap = (MAX_RUN > CNT_MAX) ? CNT_MAX : MAX_RUN;
  localparam logic [CNT_W-1:0] CntCap = CNT_W'(RunCap);
  localparam logic [CNT_W-1:0] CntStart = CNT_W'(2);

  logic                       have_r, have_nxt;
  rseg_dir_t                  dir_r, dir_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic signed [SAMPLE_W-1:0] prev_r, prev_nxt;
  logic signed [SAMPLE_W-1:0] start_r, start_nxt;

  // State after the step, before end of stream handling
  rseg_dir_t                  st_dir;
  logic [CNT_W-1:0]           st_cnt;
  logic signed [SAMPLE_W-1:0] st_start;
  logic                       accept;
  rseg_entry_t                entry;

  // Signed length of a run record
  function automatic logic signed [LEN_W-1:0] run_len(input rseg_dir_t d,
                                                      input logic [CNT_W-1:0] c);
    logic signed [LEN_W-1:0] mag;
    mag = $signed({1'b0, c});
    return (d == DIR_FALL) ? -mag : mag;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c < CntCap) ? c + 1'b1 : c;
  endfunction

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  // Step the run state and classify
  always_comb begin
    st_dir   = dir_r;
    st_cnt   = cnt_r;
    st_start = start_r;
    entry    = '0;
    entry.rev_val = start_r;
    entry.rev_len = run_len(dir_r, cnt_r);

    if (!have_r) begin
      st_dir = DIR_NONE;
    end else if (in_sample != prev_r) begin
      if (dir_r == DIR_NONE) begin
        st_dir   = (in_sample > prev_r) ? DIR_RISE : DIR_FALL;
        st_start = prev_r;
        st_cnt   = CntStart;
      end else if ((in_sample > prev_r) == (dir_r == DIR_RISE)) begin
        st_cnt = sat_inc(cnt_r);
      end else begin
        // strict reversal closes the open run
        entry.rev_vld = 1'b1;
        st_dir   = (in_sample > prev_r) ? DIR_RISE : DIR_FALL;
        st_start = prev_r;
        st_cnt   = CntStart;
      end
    end else if (dir_r != DIR_NONE) begin
      st_cnt = sat_inc(cnt_r);
    end

    entry.fin_len = run_len(st_dir, st_cnt);
    entry.fin_val = st_start;
    entry.ext_val = in_sample;
    if (in_end_of_stream) begin
      entry.fin_vld = (st_dir != DIR_NONE);
      entry.ext_vld = (st_dir == DIR_NONE) || (in_sample != st_start);
    end

    have_nxt  = 1'b1;
    dir_nxt   = st_dir;
    cnt_nxt   = st_cnt;
    start_nxt = st_start;
    prev_nxt  = in_sample;
    if (in_end_of_stream) begin
      have_nxt  = 1'b0;
      dir_nxt   = DIR_NONE;
      cnt_nxt   = '0;
      start_nxt = '0;
      prev_nxt  = '0;
    end
  end

  assign q_push  = accept && (entry.rev_vld || entry.fin_vld || entry.ext_vld);
  assign q_entry = entry;

  // Run state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r  <= 1'b0;
      dir_r   <= DIR_NONE;
      cnt_r   <= '0;
      prev_r  <= '0;
      start_r <= '0;
    end else if (accept) begin
      have_r  <= have_nxt;
      dir_r   <= dir_nxt;
      cnt_r   <= cnt_nxt;
      prev_r  <= prev_nxt;
      start_r <= start_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rseg_fifo.sv
// Short queue of classified entries between the front and back ends.
// Depends on rseg_pkg.
`default_nettype none
`include "assert_macros.svh"

module rseg_fifo
  import rseg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire rseg_entry_t wr_entry,
  input  wire logic        pop,
  output rseg_entry_t      rd_entry,
  output rseg_qstat_t      stat
);

  localparam logic [Q_PTR_W-1:0] PtrLast = Q_PTR_W'(Q_DEPTH - 1);
  localparam logic [Q_CNT_W-1:0] CntFull = Q_CNT_W'(Q_DEPTH);

  rseg_entry_t         mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]  cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == CntFull);
  assign stat.empty = (cnt_r == '0);
  assign rd_entry   = mem_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

  `ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_r <= CntFull, "queue count exceeds depth")
  `ASSERT_IMPLY(a_no_overflow, clk, rst_n, push, !stat.full || pop, "push into full queue")
  `ASSERT_IMPLY(a_no_underflow, clk, rst_n, pop, !stat.empty, "pop from empty queue")
  `ASSERT_NEXT(a_cnt_up, clk, rst_n, push && !pop, cnt_r == $past(cnt_r) + 1'b1, "count not raised")

endmodule

`default_nettype wire

### hw/rtl/rseg_back.sv
// Back end: walks the results of each queued entry in order and drives the
// registered result channel. Depends on rseg_pkg.
`default_nettype none
`include "assert_macros.svh"

module rseg_back
  import rseg_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire rseg_entry_t           q_entry,
  input  wire rseg_qstat_t           q_stat,
  output logic                       q_pop,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_kind,
  output logic signed [LEN_W-1:0]    out_run_length,
  output logic signed [SAMPLE_W-1:0] out_value,
  output logic                       out_last_result
);

  logic                       valid_r, valid_nxt;
  logic                       kind_r, kind_nxt;
  logic signed [LEN_W-1:0]    len_r, len_nxt;
  logic signed [SAMPLE_W-1:0] value_r, value_nxt;
  logic                       last_r, last_nxt;
  logic [N_SLOTS-1:0]         done_r, done_nxt;

  logic [N_SLOTS-1:0] pend;
  logic [N_SLOTS-1:0] sel;
  logic               load;

  assign pend = {q_entry.ext_vld, q_entry.fin_vld, q_entry.rev_vld} & ~done_r;
  assign load = !valid_r || out_ready;

  // Pick the first pending result of the head entry
  always_comb begin
    sel = '0;
    if (pend[SLOT_REV]) begin
      sel[SLOT_REV] = 1'b1;
    end else if (pend[SLOT_FIN]) begin
      sel[SLOT_FIN] = 1'b1;
    end else begin
      sel[SLOT_EXT] = 1'b1;
    end
  end

  // Output register load and entry retirement
  always_comb begin
    valid_nxt = valid_r;
    kind_nxt  = kind_r;
    len_nxt   = len_r;
    value_nxt = value_r;
    last_nxt  = last_r;
    done_nxt  = done_r;
    q_pop     = 1'b0;
    if (load) begin
      valid_nxt = !q_stat.empty;
      if (!q_stat.empty) begin
        last_nxt = ((pend & ~sel) == '0);
        if (sel[SLOT_REV]) begin
          kind_nxt  = KIND_RUN;
          len_nxt   = q_entry.rev_len;
          value_nxt = q_entry.rev_val;
        end else if (sel[SLOT_FIN]) begin
          kind_nxt  = KIND_RUN;
          len_nxt   = q_entry.fin_len;
          value_nxt = q_entry.fin_val;
        end else begin
          kind_nxt  = KIND_EXT;
          len_nxt   = '0;
          value_nxt = q_entry.ext_val;
        end
        if ((pend & ~sel) == '0) begin
          q_pop    = 1'b1;
          done_nxt = '0;
        end else begin
          done_nxt = done_r | sel;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      done_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      done_r  <= done_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    len_r   <= len_nxt;
    value_r <= value_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid       = valid_r;
  assign out_kind        = kind_r;
  assign out_run_length  = len_r;
  assign out_value       = value_r;
  assign out_last_result = last_r;

  `ASSERT_IMPLY(a_done_idle, clk, rst_n, q_stat.empty, done_r == '0, "progress bits set with empty queue")
  `ASSERT_IMPLY(a_head_pending, clk, rst_n, !q_stat.empty, pend != '0, "head entry has nothing left")
  `ASSERT_IMPLY(a_pop_is_last, clk, rst_n, q_pop, valid_nxt && last_nxt, "entry retired before its last result")

endmodule

`default_nettype wire

### hw/rtl/monotonic_run_segmenter_core.sv
// Top level of the monotonic run segmenter: front end, entry queue, back end.
// Depends on rseg_pkg, rseg_front, rseg_fifo and rseg_back.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_ready    in_sample[15:0], in_end_of_stream
//   out_     output     out_valid/out_ready  out_kind, out_run_length[11:0],
//                                            out_value[15:0], out_last_result
//
// A sample is taken every cycle while the two-entry queue has room; results
// pass through the queue storage and the registered result channel.
// The back end sends one result per cycle while out_ready is high; a sample
// causes k results, where k is 0 to 3.
// Reset (rst_n low at a clock edge) starts a new stream and empties the queue.
// A stalled result channel fills the queue, then drops in_ready.
`default_nettype none

module monotonic_run_segmenter_core
  import rseg_pkg::*;
#(
  parameter int unsigned MAX_RUN = 1024
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic signed [SAMPLE_W-1:0] in_sample,
  input  wire logic                       in_end_of_stream,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            out_kind,
  output logic signed [LEN_W-1:0]         out_run_length,
  output logic signed [SAMPLE_W-1:0]      out_value,
  output logic                            out_last_result
);

  rseg_qstat_t q_stat;
  rseg_entry_t wr_entry;
  rseg_entry_t rd_entry;
  logic        q_push;
  logic        q_pop;

  rseg_front #(
    .MAX_RUN (MAX_RUN)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample        (in_sample),
    .in_end_of_stream (in_end_of_stream),
    .q_stat           (q_stat),
    .q_push           (q_push),
    .q_entry          (wr_entry)
  );

  rseg_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (wr_entry),
    .pop      (q_pop),
    .rd_entry (rd_entry),
    .stat     (q_stat)
  );

  rseg_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_entry         (rd_entry),
    .q_stat          (q_stat),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_run_length  (out_run_length),
    .out_value       (out_value),
    .out_last_result (out_last_result)
  );

endmodule

`default_nettype wire

### test/testbench.sv
// Self-checking testbench for monotonic_run_segmenter_core: an in-bench predictor
// turns each accepted sample into expected run and extremum records.
// Depends on rseg_pkg and the segmenter RTL.
`default_nettype none

module testbench;
  import rseg_pkg::*;

  localparam int unsigned RUN_LIMIT    = 1024;
  localparam int unsigned RUN_CAP      = (RUN_LIMIT > CNT_MAX) ? CNT_MAX : RUN_LIMIT;
  localparam int          SETTLE_CYC   = 8;
  localparam int          DRAIN_GUARD  = 20000;
  localparam int          RANDOM_ITEMS = 100;

  // One expected or observed result record
  typedef struct {
    logic                       kind;
    logic signed [LEN_W-1:0]    len;
    logic signed [SAMPLE_W-1:0] value;
    logic                       last;
  } segment_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic                       in_end_of_stream;
  logic                       out_valid;
  logic                       out_ready;
  logic                       out_kind;
  logic signed [LEN_W-1:0]    out_run_length;
  logic signed [SAMPLE_W-1:0] out_value;
  logic                       out_last_result;

  // Predictor state
  logic signed [SAMPLE_W-1:0] prev_sample;
  logic                       have_prev;
  rseg_dir_t                  run_dir;
  logic [CNT_W-1:0]           run_cnt;
  logic signed [SAMPLE_W-1:0] run_start;

  segment_t pending_segments[$];
  int       mismatch_count;
  int       in_idle_pct;
  int       out_idle_pct;
  int       stall_request;

  monotonic_run_segmenter_core #(
    .MAX_RUN(RUN_LIMIT)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample       (in_sample),
    .in_end_of_stream(in_end_of_stream),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_run_length  (out_run_length),
    .out_value       (out_value),
    .out_last_result (out_last_result)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic segment_t make_run_record();
    segment_t r;
    r.kind  = KIND_RUN;
    r.len   = {1'b0, run_cnt};
    if (run_dir == DIR_FALL) r.len = -r.len;
    r.value = run_start;
    r.last  = 1'b0;
    return r;
  endfunction

  function automatic void clear_stream();
    prev_sample = '0;
    have_prev   = 1'b0;
    run_dir     = DIR_NONE;
    run_cnt     = '0;
    run_start   = '0;
  endfunction

  // Advance the segmenter state by one sample and queue what it emits
  function automatic void predict_segments(input logic signed [SAMPLE_W-1:0] x,
                                           input logic eos);
    segment_t  outs[N_SLOTS];
    int        n;
    rseg_dir_t step_dir;
    logic      had_run;
    n = 0;
    if (!have_prev) begin
      have_prev = 1'b1;
      run_dir   = DIR_NONE;
    end else if (x != prev_sample) begin
      step_dir = (x > prev_sample) ? DIR_RISE : DIR_FALL;
      if (run_dir == DIR_NONE) begin
        run_dir   = step_dir;
        run_start = prev_sample;
        run_cnt   = CNT_W'(2);
      end else if (step_dir == run_dir) begin
        if (run_cnt < RUN_CAP) run_cnt++;
      end else begin
        // strict reversal closes the run; the turning point opens the next
        outs[n] = make_run_record();
        n++;
        run_dir   = step_dir;
        run_start = prev_sample;
        run_cnt   = CNT_W'(2);
      end
    end else if (run_dir != DIR_NONE) begin
      if (run_cnt < RUN_CAP) run_cnt++;
    end
    prev_sample = x;

    if (eos) begin
      had_run = (run_dir != DIR_NONE);
      if (had_run) begin
        outs[n] = make_run_record();
        n++;
      end
      if (!had_run || x != run_start) begin
        outs[n].kind  = KIND_EXT;
        outs[n].len   = '0;
        outs[n].value = x;
        outs[n].last  = 1'b0;
        n++;
      end
      clear_stream();
    end

    for (int i = 0; i < n; i++) begin
      outs[i].last = (i == n - 1);
      pending_segments.push_back(outs[i]);
    end
  endfunction

  // Result checker: compare every accepted transfer with the oldest expectation
  always @(posedge clk) begin
    segment_t exp_seg;
    if (rst_n && out_valid && out_ready) begin
      if (pending_segments.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind=%0d len=%0d value=%0d last=%0d",
                                  out_kind, out_run_length, out_value, out_last_result));
      end else begin
        exp_seg = pending_segments.pop_front();
        if (out_kind !== exp_seg.kind || out_run_length !== exp_seg.len ||
            out_value !== exp_seg.value || out_last_result !== exp_seg.last) begin
          report_mismatch($sformatf(
            "got kind=%0d len=%0d value=%0d last=%0d, want kind=%0d len=%0d value=%0d last=%0d",
            out_kind, out_run_length, out_value, out_last_result,
            exp_seg.kind, exp_seg.len, exp_seg.value, exp_seg.last));
        end
      end
    end
  end

  // Result receiver: random stalls, plus a counted hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_request > 0) begin
        out_ready <= 1'b0;
        stall_request--;
      end else begin
        out_ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  // Offer one sample; called and returns at a falling edge
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic eos);
    while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_sample        <= s;
    in_end_of_stream <= eos;
    do @(posedge clk); while (!in_ready);
    predict_segments(s, eos);
    @(negedge clk);
  endtask

  // Sender pause: let every expected result arrive, then let the block settle
  task automatic wait_drained();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_segments.size() != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk);
      guard++;
    end
    if (pending_segments.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived",
                                pending_segments.size()));
      pending_segments.delete();
    end
    repeat (SETTLE_CYC) @(posedge clk);
    @(negedge clk);
  endtask

  // Field extremes, single-sample streams, flat streams, reversals
  task automatic test_directed();
    send_sample(16'sd0, 1'b1);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd32767, 1'b1);
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd32768, 1'b1);
    // leading equal samples skipped, equal samples inside the run extend it
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd9, 1'b0);
    send_sample(16'sd9, 1'b0);
    send_sample(16'sd12, 1'b1);
    // flat stream: no run, extremum only
    send_sample(-16'sd7, 1'b0);
    send_sample(-16'sd7, 1'b0);
    send_sample(-16'sd7, 1'b1);
    // reversal on the final sample gives three results
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd10, 1'b0);
    send_sample(-16'sd5, 1'b1);
    // reversals in mid-stream
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd2, 1'b0);
    send_sample(16'sd2, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(-16'sd3, 1'b0);
    send_sample(16'sd4, 1'b1);
    wait_drained();
  endtask

  // Long rising then falling run in one stream, with a few repeated samples
  task automatic test_long_runs();
    for (int i = 0; i < 20; i++) send_sample(16'((i / 3) * 7 - 30), 1'b0);
    for (int k = 1; k <= 20; k++) send_sample(16'(12 - 5 * k), k == 20);
    wait_drained();
  endtask

  // Long receiver hold-off while samples keep coming
  task automatic test_backpressure();
    stall_request = 60;
    for (int i = 0; i < 14; i++) send_sample((i % 2) ? 16'sd100 : -16'sd100, i == 13);
    send_sample(16'sd3, 1'b1);
    send_sample(-16'sd3, 1'b1);
    wait_drained();
  endtask

  // Random walks split into streams of random length
  task automatic test_random();
    int                         sent;
    int                         len;
    int                         trend;
    int                         nxt;
    int                         r;
    logic signed [SAMPLE_W-1:0] cur;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      // quiet stretch with no idling on either side
      if (sent >= 30 && sent < 70) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end else begin
        in_idle_pct  = 25;
        out_idle_pct = 25;
      end
      len   = $urandom_range(1, 12);
      trend = $urandom_range(1) ? 1 : -1;
      cur   = ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(400) - 200);
      for (int i = 0; i < len; i++) begin
        if (i > 0) begin
          r = $urandom_range(99);
          if (r < 8) begin
            cur = 16'($urandom());
          end else if (r >= 25) begin
            if ($urandom_range(3) == 0) trend = -trend;
            nxt = int'(cur) + trend * int'($urandom_range(1, 300));
            if (nxt > 32767) nxt = 32767;
            if (nxt < -32768) nxt = -32768;
            cur = 16'(nxt);
          end
        end
        send_sample(cur, i == len - 1);
        sent++;
      end
      // now and then the sender pauses for a full drain
      if ($urandom_range(9) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_sample        = '0;
    in_end_of_stream = 1'b0;
    mismatch_count   = 0;
    in_idle_pct      = 25;
    out_idle_pct     = 25;
    stall_request    = 0;
    clear_stream();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_long_runs();
    test_backpressure();
    test_random();

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Run limit
  initial begin
    #3000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire
